[hdl/nfa_pkg.sv]
// Package for the next-fit id allocator: field widths, command and status
// codes, and the geometry of the used-map memory.
// No dependencies.
package nfa_pkg;

   // Identifier space and fixed field widths
   localparam int ID_BITS   = 16;
   localparam int ID_W      = 16;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;

   // Used map: one bit per id, packed into 32-bit memory words
   localparam int WORD_BITS = 32;
   localparam int BIT_BITS  = $clog2(WORD_BITS);
   localparam int ADDR_BITS = ID_BITS - BIT_BITS;
   localparam int NWORDS    = 1 << ADDR_BITS;
   localparam int STEP_BITS = ADDR_BITS + 1;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [ID_W-1:0]      id_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [BIT_BITS-1:0]  bit_type;
   typedef logic [WORD_BITS-1:0] word_type;

   localparam cmd_type CMD_ALLOC   = 2'd0;
   localparam cmd_type CMD_CLAIM   = 2'd1;
   localparam cmd_type CMD_RELEASE = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NO_FREE   = 2'd1;
   localparam status_type ST_IN_USE    = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

endpackage

[hdl/next_fit_id_allocator.sv]
// Next-fit id allocator: used map in a single-port-write, one-read memory,
// word-wide next-fit search, claim and release by read-modify-write.
// Depends on nfa_pkg.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------
//  req      | in        | req_valid/ready   | req_cmd, req_id
//  rsp      | out       | rsp_valid/ready   | rsp_status, rsp_id_out
//
// Claim and release go from accept through the evaluate and hold states back to
// idle, unknown commands straight through hold; the result word turns valid in
// the same cycle as req_ready returns. Allocate reads one 32-id word of the map
// per cycle, starting at the word that holds the id after the pointer, and
// wraps round the whole map before it answers no free when the map is full.
// After reset the map is cleared one word a cycle, all NWORDS = 2048 words;
// req_ready stays low meanwhile. A result waiting on rsp_ready does not
// block the next accept; a second result waits until the first is taken.
module next_fit_id_allocator (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  nfa_pkg::cmd_type         req_cmd,
   input  nfa_pkg::id_type          req_id,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output nfa_pkg::status_type      rsp_status,
   output nfa_pkg::id_type          rsp_id_out
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_HOLD  = 3'd4;

   localparam nfa_pkg::addr_type ADDR_LAST = nfa_pkg::addr_type'(nfa_pkg::NWORDS - 1);
   localparam logic [nfa_pkg::STEP_BITS-1:0] STEP_LAST =
      nfa_pkg::STEP_BITS'(nfa_pkg::NWORDS);

   // Used map
   nfa_pkg::word_type mem [nfa_pkg::NWORDS];

   logic [2:0]                       state_ff, state_in;
   nfa_pkg::addr_type                addr_ff, addr_in;
   nfa_pkg::bit_type                 lo_ff, lo_in;
   logic [nfa_pkg::STEP_BITS-1:0]    step_ff, step_in;
   nfa_pkg::cmd_type                 cmd_ff, cmd_in;
   nfa_pkg::id_type                  id_ff, id_in;
   logic [nfa_pkg::ID_BITS-1:0]      last_ff, last_in;
   nfa_pkg::addr_type                clr_ff, clr_in;
   nfa_pkg::word_type                rdata_ff;
   nfa_pkg::status_type              res_status_ff, res_status_in;
   nfa_pkg::id_type                  res_id_ff, res_id_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   nfa_pkg::status_type              rsp_status_ff, rsp_status_in;
   nfa_pkg::id_type                  rsp_id_ff, rsp_id_in;

   nfa_pkg::addr_type                rd_addr;
   logic                             wr_en;
   nfa_pkg::addr_type                wr_addr;
   nfa_pkg::word_type                wr_data;

   logic                             req_fire;
   logic [nfa_pkg::ID_BITS-1:0]      next_id;
   logic [nfa_pkg::ID_BITS-1:0]      req_id_n;
   logic                             id_out_of_range;
   nfa_pkg::word_type                scan_mask;
   nfa_pkg::word_type                free_bits;
   nfa_pkg::word_type                first_free;
   nfa_pkg::bit_type                 first_idx;
   nfa_pkg::word_type                lo_onehot;
   logic                             lo_bit;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_id_out = rsp_id_ff;

   assign next_id         = last_ff + nfa_pkg::ID_BITS'(1);
   assign req_id_n        = req_id[nfa_pkg::ID_BITS-1:0];
   assign id_out_of_range = (req_id >> nfa_pkg::ID_BITS) != '0;
   assign lo_onehot       = nfa_pkg::word_type'(1) << lo_ff;
   assign lo_bit          = rdata_ff[lo_ff];

   // Search window within the current word; id 0 is never a candidate
   always_comb begin
      if (step_ff == '0) begin
         scan_mask = ~(lo_onehot - nfa_pkg::word_type'(1));
      end else if (step_ff == STEP_LAST) begin
         scan_mask = lo_onehot - nfa_pkg::word_type'(1);
      end else begin
         scan_mask = '1;
      end
      if (addr_ff == '0) begin
         scan_mask[0] = 1'b0;
      end
   end

   assign free_bits  = ~rdata_ff & scan_mask;
   assign first_free = free_bits & (~free_bits + nfa_pkg::word_type'(1));

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < nfa_pkg::WORD_BITS; i++) begin
         if (first_free[i]) begin
            first_idx = first_idx | nfa_pkg::bit_type'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      lo_in         = lo_ff;
      step_in       = step_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      last_in       = last_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = rdata_ff;

      // Drop the word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + nfa_pkg::addr_type'(1);
            if (clr_ff == ADDR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_cmd;
               id_in   = req_id;
               step_in = '0;
               if (req_cmd == nfa_pkg::CMD_ALLOC) begin
                  addr_in  = next_id[nfa_pkg::ID_BITS-1:nfa_pkg::BIT_BITS];
                  lo_in    = next_id[nfa_pkg::BIT_BITS-1:0];
                  rd_addr  = addr_in;
                  state_in = S_SCAN;
               end else if ((req_cmd == nfa_pkg::CMD_CLAIM ||
                             req_cmd == nfa_pkg::CMD_RELEASE) && !id_out_of_range) begin
                  addr_in  = req_id_n[nfa_pkg::ID_BITS-1:nfa_pkg::BIT_BITS];
                  lo_in    = req_id_n[nfa_pkg::BIT_BITS-1:0];
                  rd_addr  = addr_in;
                  state_in = S_EVAL;
               end else begin
                  res_status_in = (req_cmd == nfa_pkg::CMD_CLAIM) ?
                                  nfa_pkg::ST_IN_USE : nfa_pkg::ST_NOT_FOUND;
                  res_id_in     = '0;
                  state_in      = S_HOLD;
               end
            end
         end
         S_SCAN: begin
            // Read ahead one word; a read past the hit is simply dropped
            rd_addr = addr_ff + nfa_pkg::addr_type'(1);
            if (free_bits != '0) begin
               wr_en         = 1'b1;
               wr_addr       = addr_ff;
               wr_data       = rdata_ff | first_free;
               last_in       = {addr_ff, first_idx};
               res_status_in = nfa_pkg::ST_OK;
               res_id_in     = nfa_pkg::id_type'({addr_ff, first_idx});
               state_in      = S_HOLD;
            end else if (step_ff == STEP_LAST) begin
               res_status_in = nfa_pkg::ST_NO_FREE;
               res_id_in     = '0;
               state_in      = S_HOLD;
            end else begin
               addr_in = addr_ff + nfa_pkg::addr_type'(1);
               step_in = step_ff + nfa_pkg::STEP_BITS'(1);
            end
         end
         S_EVAL: begin
            wr_addr = addr_ff;
            if (cmd_ff == nfa_pkg::CMD_CLAIM) begin
               if (id_ff == '0 || lo_bit) begin
                  res_status_in = nfa_pkg::ST_IN_USE;
                  res_id_in     = '0;
               end else begin
                  wr_en         = 1'b1;
                  wr_data       = rdata_ff | lo_onehot;
                  res_status_in = nfa_pkg::ST_OK;
                  res_id_in     = id_ff;
               end
            end else begin
               res_id_in = '0;
               if (lo_bit) begin
                  wr_en         = 1'b1;
                  wr_data       = rdata_ff & ~lo_onehot;
                  res_status_in = nfa_pkg::ST_OK;
               end else begin
                  res_status_in = nfa_pkg::ST_NOT_FOUND;
               end
            end
            state_in = S_HOLD;
         end
         S_HOLD: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      lo_ff         <= lo_in;
      step_ff       <= step_in;
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

endmodule

[dv/next_fit_id_allocator_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for next_fit_id_allocator: a queue-fed request driver, a response
// monitor and a next-fit allocation predictor over the whole id space. Depends on nfa_pkg.
module next_fit_id_allocator_tb;

   // Command 3 has no meaning; the block answers it with not found.
   localparam nfa_pkg::cmd_type CMD_UNDEFINED = 2'd3;
   localparam int      ID_SPACE      = 1 << nfa_pkg::ID_BITS;
   localparam int      QUIET_LIMIT   = 25000;

   typedef struct packed {
      nfa_pkg::cmd_type cmd;
      nfa_pkg::id_type  id;
   } req_word_type;

   typedef struct packed {
      nfa_pkg::status_type status;
      nfa_pkg::id_type     id_out;
   } rsp_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   nfa_pkg::cmd_type    req_cmd = nfa_pkg::CMD_ALLOC;
   nfa_pkg::id_type     req_id = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   nfa_pkg::status_type rsp_status;
   nfa_pkg::id_type     rsp_id_out;

   // Predictor state: one bit per id and the next-fit pointer
   bit              id_taken [ID_SPACE];
   nfa_pkg::id_type alloc_ptr = '0;
   nfa_pkg::id_type held_ids [$];

   req_word_type pending_req_q [$];
   rsp_word_type expected_rsp_q [$];
   req_word_type next_req;
   rsp_word_type seen_rsp;

   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          pause_send = 1'b0;
   int          pushed_count = 0;
   int          accepted_count = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;

   next_fit_id_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_id     (req_id),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_id_out (rsp_id_out)
   );

   always #5 clock = ~clock;

   function automatic rsp_word_type next_fit_outcome(nfa_pkg::cmd_type cmd,
                                                     nfa_pkg::id_type id);
      rsp_word_type    r;
      nfa_pkg::id_type cur;
      r.status = nfa_pkg::ST_NOT_FOUND;
      r.id_out = '0;
      case (cmd)
         nfa_pkg::CMD_ALLOC: begin
            r.status = nfa_pkg::ST_NO_FREE;
            cur = alloc_ptr;
            // full lap, so the pointer's own id is tried last
            for (int n = 0; n < ID_SPACE; n++) begin
               cur = cur + 1'b1;
               if (cur != '0 && !id_taken[cur]) begin
                  id_taken[cur] = 1'b1;
                  alloc_ptr = cur;
                  held_ids = {held_ids, cur};
                  r.status = nfa_pkg::ST_OK;
                  r.id_out = cur;
                  break;
               end
            end
         end
         nfa_pkg::CMD_CLAIM: begin
            if (id == '0 || id_taken[id]) begin
               r.status = nfa_pkg::ST_IN_USE;
            end else begin
               id_taken[id] = 1'b1;
               held_ids = {held_ids, id};
               r.status = nfa_pkg::ST_OK;
               r.id_out = id;
            end
         end
         nfa_pkg::CMD_RELEASE: begin
            if (id != '0 && id_taken[id]) begin
               id_taken[id] = 1'b0;
               r.status = nfa_pkg::ST_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic note_fault(string msg);
      fail_count++;
      $error("%s", msg);
   endtask

   // Driver: one request word in flight, held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q = {expected_rsp_q, next_fit_outcome(req_cmd, req_id)};
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (!pause_send && pending_req_q.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
               next_req = pending_req_q.pop_front();
               req_cmd   <= next_req.cmd;
               req_id    <= next_req.id;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response word with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               note_fault($sformatf("unexpected response: status %0d id_out %0d",
                                    rsp_status, rsp_id_out));
            end else begin
               seen_rsp = expected_rsp_q.pop_front();
               if (rsp_status !== seen_rsp.status)
                  note_fault($sformatf("status: expected %0d, actual %0d",
                                       seen_rsp.status, rsp_status));
               if (rsp_id_out !== seen_rsp.id_out)
                  note_fault($sformatf("id_out: expected %0d, actual %0d",
                                       seen_rsp.id_out, rsp_id_out));
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: cycles in which neither channel moves a word
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_req(nfa_pkg::cmd_type cmd, nfa_pkg::id_type id);
      req_word_type w;
      w.cmd = cmd;
      w.id  = id;
      pending_req_q = {pending_req_q, w};
      pushed_count++;
   endtask

   task automatic wait_accepted();
      while (accepted_count != pushed_count)
         @(negedge clock);
   endtask

   task automatic wait_drained();
      wait_accepted();
      while (expected_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   // Pick an id that is in use now, or a random id when none is held; drop stale entries on the way.
   function automatic nfa_pkg::id_type pick_held();
      int idx;
      while (held_ids.size() > 0) begin
         idx = $urandom_range(held_ids.size() - 1);
         if (id_taken[held_ids[idx]])
            return held_ids[idx];
         held_ids.delete(idx);
      end
      return nfa_pkg::id_type'($urandom);
   endfunction

   task automatic push_random();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35)
         push_req(nfa_pkg::CMD_ALLOC, nfa_pkg::id_type'($urandom));
      else if (pick < 50)
         push_req(nfa_pkg::CMD_CLAIM, nfa_pkg::id_type'($urandom));
      else if (pick < 58)
         // claim just ahead of the pointer so that allocate has to skip
         push_req(nfa_pkg::CMD_CLAIM,
                  alloc_ptr + nfa_pkg::id_type'($urandom_range(1, 40)));
      else if (pick < 62)
         push_req(nfa_pkg::CMD_CLAIM,
                  ($urandom_range(1) != 0) ? nfa_pkg::id_type'('0) : pick_held());
      else if (pick < 85)
         push_req(nfa_pkg::CMD_RELEASE, pick_held());
      else if (pick < 93)
         push_req(nfa_pkg::CMD_RELEASE, nfa_pkg::id_type'($urandom));
      else
         push_req(CMD_UNDEFINED, nfa_pkg::id_type'($urandom));
   endtask

   initial begin
      int unsigned     sender_pct [5];
      int unsigned     stall_pct [5];
      nfa_pkg::id_type freed_id;
      sender_pct = '{0, 78, 0, 24, 0};
      stall_pct  = '{0, 0, 78, 24, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words on an empty map
      push_req(nfa_pkg::CMD_ALLOC, 16'hFFFF);
      push_req(nfa_pkg::CMD_ALLOC, 16'h0000);
      push_req(nfa_pkg::CMD_CLAIM, 16'h0000);
      push_req(nfa_pkg::CMD_CLAIM, 16'hFFFF);
      push_req(nfa_pkg::CMD_CLAIM, 16'hFFFF);
      push_req(nfa_pkg::CMD_CLAIM, 16'd3);
      push_req(nfa_pkg::CMD_ALLOC, 16'h1234);
      push_req(nfa_pkg::CMD_RELEASE, 16'h0000);
      push_req(nfa_pkg::CMD_RELEASE, 16'd2);
      push_req(nfa_pkg::CMD_RELEASE, 16'd2);
      push_req(nfa_pkg::CMD_ALLOC, 16'h0000);
      push_req(CMD_UNDEFINED, 16'hFFFF);
      push_req(CMD_UNDEFINED, 16'h0000);
      push_req(nfa_pkg::CMD_RELEASE, 16'hFFFF);
      push_req(nfa_pkg::CMD_CLAIM, 16'd32);
      push_req(nfa_pkg::CMD_CLAIM, 16'd6);
      push_req(nfa_pkg::CMD_ALLOC, 16'h0000);
      push_req(nfa_pkg::CMD_CLAIM, 16'hAAAA);
      push_req(nfa_pkg::CMD_RELEASE, 16'h5555);
      push_req(nfa_pkg::CMD_RELEASE, 16'hAAAA);
      push_req(nfa_pkg::CMD_CLAIM, 16'h8000);
      push_req(nfa_pkg::CMD_ALLOC, 16'h7FFF);

      // Random words in batches, so that picks follow the live map
      for (int ph = 0; ph < 5; ph++) begin
         sender_idle_pct = sender_pct[ph];
         rsp_stall_pct   = stall_pct[ph];
         for (int b = 0; b < 9; b++) begin
            wait_accepted();
            for (int k = 0; k < 10; k++)
               push_random();
            if (ph == 1 && b == 4) begin
               // hold new words until every response is back
               pause_send = 1'b1;
               while (expected_rsp_q.size() != 0 || req_valid || accepted_count == 0)
                  @(negedge clock);
               pause_send = 1'b0;
            end
         end
      end

      // Corner cases on the live map
      wait_drained();
      sender_idle_pct = 24;
      rsp_stall_pct   = 24;
      freed_id = pick_held();
      push_req(nfa_pkg::CMD_CLAIM, freed_id);
      push_req(nfa_pkg::CMD_RELEASE, freed_id);
      push_req(nfa_pkg::CMD_RELEASE, pick_held());
      push_req(nfa_pkg::CMD_RELEASE, pick_held());
      push_req(nfa_pkg::CMD_CLAIM, freed_id);
      push_req(nfa_pkg::CMD_CLAIM, 16'h0000);
      push_req(nfa_pkg::CMD_RELEASE, 16'h0000);
      push_req(CMD_UNDEFINED, 16'h5A5A);
      push_req(nfa_pkg::CMD_ALLOC, 16'h0000);
      push_req(nfa_pkg::CMD_ALLOC, 16'hFFFF);
      push_req(nfa_pkg::CMD_ALLOC, 16'h0000);
      push_req(nfa_pkg::CMD_CLAIM, freed_id);

      wait_drained();
      repeat (20) @(negedge clock);
      if (expected_rsp_q.size() != 0)
         note_fault($sformatf("%0d responses never arrived", expected_rsp_q.size()));
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/nfa_pkg.sv
hdl/next_fit_id_allocator.sv
dv/next_fit_id_allocator_tb.sv
